// ===== hw/rtl/a64dp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing execute: shared package
// Widths, encoding codes and the result record used across the block.
// ----------------------------------------------------------------------------
package a64dp_pkg;

   localparam int XLEN       = 64;
   localparam int HALF       = 32;
   localparam int IDX_W      = 5;
   localparam int INST_W     = 32;
   localparam int FLAG_W     = 4;
   localparam int SHAMT_W    = 6;
   localparam int REG_COUNT  = 31;
   localparam int RSP_DATA_W = 80;

   localparam logic [2:0]        DP_REG_CLASS = 3'b101;
   localparam logic [3:0]        MUL_OPR      = 4'b1000;
   localparam logic [FLAG_W-1:0] FLAGS_RESET  = 4'b0100;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   typedef enum logic [1:0] {
      LOGIC_AND  = 2'd0,
      LOGIC_ORR  = 2'd1,
      LOGIC_EOR  = 2'd2,
      LOGIC_ANDS = 2'd3
   } logic_op_type;

   typedef struct packed {
      logic              write_enable;
      logic [IDX_W-1:0]  dest_index;
      logic [XLEN-1:0]   write_value;
      logic [FLAG_W-1:0] flags_after;
      logic              illegal;
   } exec_res_type;

endpackage

// ===== hw/rtl/arm64_dp_register_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing (register) execute stage
// Executes ADD/SUB(S) shifted, logical ops and MADD/MSUB against an
// in-place general register file and the NZCV flags.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one instruction word per request; rsp_* returns one record
//  per request, in order: write enable, Rd, value written, NZCV, illegal.
//  A request is taken into the operand register, with Rn/Rm/Ra read from
//  the register file (the write of the preceding instruction is bypassed).
//  It executes when the output register is free and lands in it, which
//  also writes the register file and flags; rsp_tvalid rises as the
//  result is registered.
//  Throughput: one instruction a cycle while rsp_tready stays high.
//  MADD/MSUB hold the execute stage while the 32x32 partial products
//  are registered, and then accumulate from those registers.
//  Reset clears the registers to zero (per-entry valid bits, no sweep),
//  sets the flags to Z, and empties both stages.
//  With rsp_tready low the output register holds; the operand stage still
//  fills, and req_tready drops once both are occupied.
// ----------------------------------------------------------------------------
module arm64_dp_register_execute #(
   parameter int REG_COUNT = a64dp_pkg::REG_COUNT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] instruction_word
   input  logic [a64dp_pkg::INST_W-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] write_enable, [5:1] dest_index, [69:6] write_value,
   // [73:70] flags_after, [74] illegal, [79:75] zero
   output logic [a64dp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                              s1_valid_ff, s1_valid_in;
   logic                              phase_ff, phase_in;
   logic [a64dp_pkg::INST_W-1:0]      inst_ff;
   logic [a64dp_pkg::FLAG_W-1:0]      flags_ff, flags_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   a64dp_pkg::exec_res_type           rsp_res_ff;
   a64dp_pkg::exec_res_type           res;
   logic [a64dp_pkg::XLEN-1:0]        rn_data, rm_data, ra_data;
   logic                              is_mul, mul_wait, out_free, fire, accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mul_wait   = s1_valid_ff && is_mul && !phase_ff;
   assign fire       = s1_valid_ff && !mul_wait && out_free;
   assign req_tready = !s1_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      priority if (accept || fire) begin
         phase_in = 1'b0;
      end else if (mul_wait) begin
         phase_in = 1'b1;
      end else begin
         phase_in = phase_ff;
      end
      flags_in     = fire ? res.flags_after : flags_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         flags_ff     <= a64dp_pkg::FLAGS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         inst_ff <= req_tdata;
      end
      if (fire) begin
         rsp_res_ff <= res;
      end
   end

   a64dp_regfile #(
      .REG_COUNT (REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .ren     (accept),
      .rn_idx  (req_tdata[9:5]),
      .rm_idx  (req_tdata[20:16]),
      .ra_idx  (req_tdata[14:10]),
      .we      (fire && res.write_enable),
      .widx    (res.dest_index),
      .wdata   (res.write_value),
      .rn_data (rn_data),
      .rm_data (rm_data),
      .ra_data (ra_data)
   );

   a64dp_exec #(
      .REG_COUNT (REG_COUNT)
   ) u_exec (
      .clock   (clock),
      .inst    (inst_ff),
      .rn_data (rn_data),
      .rm_data (rm_data),
      .ra_data (ra_data),
      .flags   (flags_ff),
      .pp_load (mul_wait),
      .is_mul  (is_mul),
      .res     (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000,
                        rsp_res_ff.illegal,
                        rsp_res_ff.flags_after,
                        rsp_res_ff.write_value,
                        rsp_res_ff.dest_index,
                        rsp_res_ff.write_enable};

endmodule

// ===== hw/rtl/a64dp_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing execute: general register file
// Two banks, one write port each; registered reads at Rn/Rm and Ra, with
// per-entry valid bits for reset and a bypass of the write in flight.
// ----------------------------------------------------------------------------
module a64dp_regfile #(
   parameter int REG_COUNT = a64dp_pkg::REG_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ren,
   input  logic [a64dp_pkg::IDX_W-1:0]  rn_idx,
   input  logic [a64dp_pkg::IDX_W-1:0]  rm_idx,
   input  logic [a64dp_pkg::IDX_W-1:0]  ra_idx,
   input  logic                         we,
   input  logic [a64dp_pkg::IDX_W-1:0]  widx,
   input  logic [a64dp_pkg::XLEN-1:0]   wdata,
   output logic [a64dp_pkg::XLEN-1:0]   rn_data,
   output logic [a64dp_pkg::XLEN-1:0]   rm_data,
   output logic [a64dp_pkg::XLEN-1:0]   ra_data
);

   localparam logic [a64dp_pkg::IDX_W:0] LIMIT = (a64dp_pkg::IDX_W + 1)'(REG_COUNT);

   logic [a64dp_pkg::XLEN-1:0] bank_a [REG_COUNT];
   logic [a64dp_pkg::XLEN-1:0] bank_b [REG_COUNT];
   logic [REG_COUNT-1:0]       valid_ff;
   logic [REG_COUNT-1:0]       valid_in;

   logic [a64dp_pkg::XLEN-1:0] rn_q_ff, rm_q_ff, ra_q_ff, byp_data_ff;
   logic rn_hit_ff, rm_hit_ff, ra_hit_ff;
   logic rn_hit_in, rm_hit_in, ra_hit_in;
   logic rn_byp_ff, rm_byp_ff, ra_byp_ff;
   logic rn_byp_in, rm_byp_in, ra_byp_in;
   logic w_ok, rn_ok, rm_ok, ra_ok;

   assign w_ok  = we && ({1'b0, widx} < LIMIT);
   assign rn_ok = {1'b0, rn_idx} < LIMIT;
   assign rm_ok = {1'b0, rm_idx} < LIMIT;
   assign ra_ok = {1'b0, ra_idx} < LIMIT;

   always_comb begin
      valid_in = valid_ff;
      if (w_ok) begin
         valid_in[widx] = 1'b1;
      end
   end

   assign rn_hit_in = rn_ok && valid_ff[rn_idx];
   assign rm_hit_in = rm_ok && valid_ff[rm_idx];
   assign ra_hit_in = ra_ok && valid_ff[ra_idx];
   assign rn_byp_in = w_ok && (widx == rn_idx);
   assign rm_byp_in = w_ok && (widx == rm_idx);
   assign ra_byp_in = w_ok && (widx == ra_idx);

   always_ff @(posedge clock) begin
      if (w_ok) begin
         bank_a[widx] <= wdata;
         bank_b[widx] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ren) begin
         if (rn_ok) begin
            rn_q_ff <= bank_a[rn_idx];
         end
         if (rm_ok) begin
            rm_q_ff <= bank_a[rm_idx];
         end
         if (ra_ok) begin
            ra_q_ff <= bank_b[ra_idx];
         end
         byp_data_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rn_hit_ff <= 1'b0;
         rm_hit_ff <= 1'b0;
         ra_hit_ff <= 1'b0;
         rn_byp_ff <= 1'b0;
         rm_byp_ff <= 1'b0;
         ra_byp_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ren) begin
            rn_hit_ff <= rn_hit_in;
            rm_hit_ff <= rm_hit_in;
            ra_hit_ff <= ra_hit_in;
            rn_byp_ff <= rn_byp_in;
            rm_byp_ff <= rm_byp_in;
            ra_byp_ff <= ra_byp_in;
         end
      end
   end

   assign rn_data = rn_byp_ff ? byp_data_ff : (rn_hit_ff ? rn_q_ff : '0);
   assign rm_data = rm_byp_ff ? byp_data_ff : (rm_hit_ff ? rm_q_ff : '0);
   assign ra_data = ra_byp_ff ? byp_data_ff : (ra_hit_ff ? ra_q_ff : '0);

endmodule

// ===== hw/rtl/a64dp_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing execute: decode and datapath
// Shifter, adder with NZCV, logic unit, and a two-step multiply-accumulate
// built from registered 32x32 partial products.
// ----------------------------------------------------------------------------
module a64dp_exec #(
   parameter int REG_COUNT = a64dp_pkg::REG_COUNT
) (
   input  logic                          clock,
   input  logic [a64dp_pkg::INST_W-1:0]  inst,
   input  logic [a64dp_pkg::XLEN-1:0]    rn_data,
   input  logic [a64dp_pkg::XLEN-1:0]    rm_data,
   input  logic [a64dp_pkg::XLEN-1:0]    ra_data,
   input  logic [a64dp_pkg::FLAG_W-1:0]  flags,
   input  logic                          pp_load,
   output logic                          is_mul,
   output a64dp_pkg::exec_res_type       res
);

   localparam int XLEN = a64dp_pkg::XLEN;
   localparam int HALF = a64dp_pkg::HALF;
   localparam logic [a64dp_pkg::IDX_W:0] LIMIT = (a64dp_pkg::IDX_W + 1)'(REG_COUNT);

   logic                            wide, mbit, mul_sub;
   logic [1:0]                      opc;
   logic [2:0]                      cls;
   logic [3:0]                      opr;
   logic [a64dp_pkg::SHAMT_W-1:0]   shamt, amt;
   logic [a64dp_pkg::IDX_W-1:0]     rd;
   logic [XLEN-1:0]                 mask, op_a, op_b, acc, b_ext, sh_b;
   logic [2*XLEN-1:0]               rot_w;
   logic [XLEN-1:0]                 rot_n;
   logic                            sub;
   logic [XLEN-1:0]                 bx, ar_r, lb, lg_r, mul_r, prod, result;
   logic [XLEN:0]                   sum;
   logic                            carry, ovf, n_ar, n_lg, bad;
   logic [a64dp_pkg::FLAG_W-1:0]    new_flags;
   logic [XLEN-1:0]                 pp_lo_ff, pp_lo_in;
   logic [HALF-1:0]                 pp_x_ff, pp_x_in;

   assign wide    = inst[31];
   assign opc     = inst[30:29];
   assign mbit    = inst[28];
   assign cls     = inst[27:25];
   assign opr     = inst[24:21];
   assign shamt   = inst[15:10];
   assign mul_sub = inst[15];
   assign rd      = inst[4:0];

   assign mask = wide ? '1 : {{HALF{1'b0}}, {HALF{1'b1}}};
   assign op_a = rn_data & mask;
   assign op_b = rm_data & mask;
   assign acc  = ra_data & mask;
   assign amt  = shamt & (wide ? 6'd63 : 6'd31);

   // operand shifter
   assign b_ext = wide ? op_b : {{HALF{op_b[HALF-1]}}, op_b[HALF-1:0]};
   assign rot_w = {op_b, op_b} >> amt;
   assign rot_n = {op_b[HALF-1:0], op_b[HALF-1:0]} >> amt;

   always_comb begin
      unique case (a64dp_pkg::shift_type'(opr[2:1]))
         a64dp_pkg::SHIFT_LSL: sh_b = (op_b << amt) & mask;
         a64dp_pkg::SHIFT_LSR: sh_b = op_b >> amt;
         a64dp_pkg::SHIFT_ASR: sh_b = XLEN'($signed(b_ext) >>> amt) & mask;
         a64dp_pkg::SHIFT_ROR: sh_b = wide ? rot_w[XLEN-1:0]
                                           : {{HALF{1'b0}}, rot_n[HALF-1:0]};
         default:              sh_b = '0;
      endcase
   end

   // add / subtract
   assign sub   = opc[1];
   assign bx    = sub ? (~sh_b & mask) : sh_b;
   assign sum   = {1'b0, op_a} + {1'b0, bx} + (XLEN + 1)'(sub);
   assign ar_r  = sum[XLEN-1:0] & mask;
   assign carry = wide ? sum[XLEN] : sum[HALF];
   assign ovf   = wide ? (~(op_a[XLEN-1] ^ bx[XLEN-1]) & (op_a[XLEN-1] ^ ar_r[XLEN-1]))
                       : (~(op_a[HALF-1] ^ bx[HALF-1]) & (op_a[HALF-1] ^ ar_r[HALF-1]));
   assign n_ar  = wide ? ar_r[XLEN-1] : ar_r[HALF-1];

   // logic unit
   assign lb = opr[0] ? (~sh_b & mask) : sh_b;
   always_comb begin
      unique case (a64dp_pkg::logic_op_type'(opc))
         a64dp_pkg::LOGIC_AND:  lg_r = op_a & lb;
         a64dp_pkg::LOGIC_ORR:  lg_r = op_a | lb;
         a64dp_pkg::LOGIC_EOR:  lg_r = op_a ^ lb;
         a64dp_pkg::LOGIC_ANDS: lg_r = op_a & lb;
         default:               lg_r = '0;
      endcase
   end
   assign n_lg = wide ? lg_r[XLEN-1] : lg_r[HALF-1];

   // multiply: partial products first, accumulate next cycle
   assign pp_lo_in = op_a[HALF-1:0] * op_b[HALF-1:0];
   assign pp_x_in  = op_a[HALF-1:0] * op_b[XLEN-1:HALF]
                   + op_a[XLEN-1:HALF] * op_b[HALF-1:0];

   always_ff @(posedge clock) begin
      if (pp_load) begin
         pp_lo_ff <= pp_lo_in;
         pp_x_ff  <= pp_x_in;
      end
   end

   assign prod  = pp_lo_ff + {pp_x_ff, {HALF{1'b0}}};
   assign mul_r = (mul_sub ? (acc - prod) : (acc + prod)) & mask;

   // decode and select
   always_comb begin
      bad       = 1'b0;
      is_mul    = 1'b0;
      result    = '0;
      new_flags = flags;
      priority if (cls != a64dp_pkg::DP_REG_CLASS) begin
         bad = 1'b1;
      end else if (!mbit) begin
         priority if (!wide && shamt[5]) begin
            bad = 1'b1;
         end else if (opr[3]) begin
            if (opr[0] || (opr[2:1] == a64dp_pkg::SHIFT_ROR)) begin
               bad = 1'b1;
            end else begin
               result = ar_r;
               if (opc[0]) begin
                  new_flags = {n_ar, ar_r == '0, carry, ovf};
               end
            end
         end else begin
            result = lg_r;
            if (opc == a64dp_pkg::LOGIC_ANDS) begin
               new_flags = {n_lg, lg_r == '0, 2'b00};
            end
         end
      end else begin
         if (opr != a64dp_pkg::MUL_OPR) begin
            bad = 1'b1;
         end else begin
            is_mul = 1'b1;
            result = mul_r;
         end
      end
   end

   always_comb begin
      res.dest_index   = rd;
      res.illegal      = bad;
      res.write_enable = !bad && ({1'b0, rd} < LIMIT);
      res.write_value  = res.write_enable ? result : '0;
      res.flags_after  = bad ? flags : new_flags;
   end

endmodule

// ===== hw/rtl/a64dp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A64 data-processing execute: port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module a64dp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [a64dp_pkg::INST_W-1:0]      req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [a64dp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_illegal_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[74] |-> !rsp_tdata[0] && (rsp_tdata[69:6] == '0))
      else $error("illegal request wrote a register");

   a_zero_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> (rsp_tdata[5:1] != 5'd31) && !rsp_tdata[74])
      else $error("write reported for the zero register");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting request changed");

endmodule

bind arm64_dp_register_execute a64dp_checker u_checker (.*);
